// ===== hdl/xbfe_pkg.sv =====
// Shared types and constants of the XOR parity block FEC encoder.
package xbfe_pkg;

    localparam int LEN_W   = 16;
    localparam int BLK_W   = 16;
    localparam int SYM_W   = 8;
    localparam int DATA_W  = 64;
    localparam int IDX_W   = 8;
    localparam int SPB_W   = 8;
    localparam int LANES   = 8;

    localparam logic [SPB_W-1:0] SPB_RESET = 8'd4;

    // Header bytes that routers rewrite; they are coded as zero.
    localparam int HOP_LIMIT_BYTE = 7;
    localparam int DST_FIRST_BYTE = 24;
    localparam int DST_LAST_BYTE  = 39;
    localparam int SEG_LEFT_BYTE  = 43;

    localparam logic MODE_DATA = 1'b0;
    localparam logic MODE_READ = 1'b1;

    localparam int RES_FIFO_DEPTH = 3;
    localparam int RES_CNT_W      = 2;

    typedef enum logic [1:0] {
        ST_CODED        = 2'd0,
        ST_REPAIR_READY = 2'd1,
        ST_TOO_BIG      = 2'd2,
        ST_READ         = 2'd3
    } status_t;

    // Command handed from the accept stage to the merge stage.
    typedef struct packed {
        logic              write_en;
        logic              hit;
        logic              has_result;
        status_t           status;
        logic [BLK_W-1:0]  block;
        logic [SYM_W-1:0]  symbol;
        logic [LEN_W-1:0]  rlen;
        logic [LEN_W-1:0]  lpar;
        logic [DATA_W-1:0] data;
    } cmd_t;

    typedef struct packed {
        status_t           status;
        logic [BLK_W-1:0]  block;
        logic [SYM_W-1:0]  symbol;
        logic [DATA_W-1:0] word;
        logic [LEN_W-1:0]  rlen;
        logic [LEN_W-1:0]  lpar;
    } result_t;

endpackage

// ===== hdl/xbfe_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
module xbfe_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Read returns the old contents when the same address is written.
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

// ===== hdl/xbfe_ctrl.sv =====
// Accept stage: packet counters, byte masking and store read issue.
module xbfe_ctrl #(
    parameter int MAX_PACKET_WORDS = 256,
    localparam int AW = $clog2(MAX_PACKET_WORDS),
    localparam int PW = $clog2(MAX_PACKET_WORDS + 1)
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [xbfe_pkg::SPB_W-1:0]     cfg_write_data,
    input  logic                           accept,
    input  logic                           mode,
    input  logic [xbfe_pkg::DATA_W-1:0]    data_word,
    input  logic                           last_word,
    input  logic [xbfe_pkg::LEN_W-1:0]     pkt_len,
    input  logic [xbfe_pkg::IDX_W-1:0]     read_index,
    output logic                           rd_en,
    output logic [AW-1:0]                  rd_addr,
    output logic                           s1_valid,
    output logic [AW-1:0]                  s1_addr,
    output xbfe_pkg::cmd_t                 s1_cmd
);

    import xbfe_pkg::*;

    localparam logic [LEN_W-1:0] MaxBytes = LEN_W'(8 * MAX_PACKET_WORDS);
    localparam logic [PW-1:0]    MaxWords = PW'(MAX_PACKET_WORDS);

    logic [SPB_W-1:0] spb_reg;
    logic [PW-1:0]    pos_reg, pos_next;
    logic [PW-1:0]    fill_reg, fill_next;
    logic [BLK_W-1:0] block_reg, block_next;
    logic [SYM_W-1:0] sym_reg, sym_next;
    logic [LEN_W-1:0] max_reg, max_next;
    logic [LEN_W-1:0] xor_reg, xor_next;
    logic             s1_valid_reg;
    logic [AW-1:0]    s1_addr_reg, addr_next;
    cmd_t             s1_cmd_reg, cmd_next;

    logic [SPB_W-1:0]  spb_eff;
    logic              too_big, clear_blk, pos_in, code, written, repair_ready;
    logic [PW-1:0]     fill_eff;
    logic [LEN_W-1:0]  max_eff, xor_eff, len_max;
    logic [LEN_W-1:0]  byte_idx [LANES];
    logic [DATA_W-1:0] coded;

    assign spb_eff      = (spb_reg == '0) ? SPB_W'(1) : spb_reg;
    assign too_big      = pkt_len > MaxBytes;
    assign clear_blk    = (pos_reg == '0) && (sym_reg == '0);
    assign fill_eff     = clear_blk ? '0 : fill_reg;
    assign max_eff      = clear_blk ? '0 : max_reg;
    assign xor_eff      = clear_blk ? '0 : xor_reg;
    assign pos_in       = pos_reg < MaxWords;
    assign code         = !too_big && pos_in;
    // Store words below the fill mark hold data of the current block.
    assign written      = pos_reg < fill_eff;
    assign len_max      = (pkt_len > max_eff) ? pkt_len : max_eff;
    assign repair_ready = ({1'b0, sym_reg} + 9'd1) >= {1'b0, spb_eff};

    always_comb
    begin
        for (int lane = 0; lane < LANES; lane++)
        begin
            byte_idx[lane] = LEN_W'({pos_reg, 3'b000}) + LEN_W'(lane);
            if ((byte_idx[lane] == LEN_W'(HOP_LIMIT_BYTE)) ||
                ((byte_idx[lane] >= LEN_W'(DST_FIRST_BYTE)) &&
                 (byte_idx[lane] <= LEN_W'(DST_LAST_BYTE))) ||
                (byte_idx[lane] == LEN_W'(SEG_LEFT_BYTE)) ||
                (byte_idx[lane] >= pkt_len))
            begin
                coded[8*lane +: 8] = 8'h00;
            end
            else
            begin
                coded[8*lane +: 8] = data_word[8*lane +: 8];
            end
        end
    end

    always_comb
    begin
        pos_next   = pos_reg;
        fill_next  = fill_reg;
        block_next = block_reg;
        sym_next   = sym_reg;
        max_next   = max_reg;
        xor_next   = xor_reg;
        addr_next  = AW'(pos_reg);

        cmd_next            = '0;
        cmd_next.status     = ST_CODED;
        cmd_next.block      = block_reg;
        cmd_next.symbol     = sym_reg;
        cmd_next.rlen       = max_reg;
        cmd_next.lpar       = xor_reg;

        if (accept)
        begin
            if (mode == MODE_READ)
            begin
                addr_next           = AW'(read_index);
                cmd_next.hit        = 32'(read_index) < 32'(fill_reg);
                cmd_next.has_result = 1'b1;
                cmd_next.status     = ST_READ;
            end
            else
            begin
                max_next          = max_eff;
                xor_next          = xor_eff;
                // An oversize word still claims its entry, as zero, so the fill mark
                // never leaves a hole below it.
                fill_next         = (pos_in && !written) ? pos_reg + PW'(1) : fill_eff;
                cmd_next.write_en = pos_in;
                cmd_next.hit      = written;
                cmd_next.data     = code ? coded : '0;
                if (!last_word)
                begin
                    if (pos_in)
                    begin
                        pos_next = pos_reg + PW'(1);
                    end
                end
                else
                begin
                    pos_next            = '0;
                    cmd_next.has_result = 1'b1;
                    if (too_big)
                    begin
                        cmd_next.status = ST_TOO_BIG;
                        cmd_next.rlen   = max_eff;
                        cmd_next.lpar   = xor_eff;
                    end
                    else
                    begin
                        max_next      = len_max;
                        xor_next      = xor_eff ^ pkt_len;
                        cmd_next.rlen = len_max;
                        cmd_next.lpar = xor_eff ^ pkt_len;
                        if (repair_ready)
                        begin
                            cmd_next.status = ST_REPAIR_READY;
                            block_next      = block_reg + BLK_W'(1);
                            sym_next        = '0;
                        end
                        else
                        begin
                            cmd_next.status = ST_CODED;
                            sym_next        = sym_reg + SYM_W'(1);
                        end
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            spb_reg      <= SPB_RESET;
            pos_reg      <= '0;
            fill_reg     <= '0;
            block_reg    <= '0;
            sym_reg      <= '0;
            max_reg      <= '0;
            xor_reg      <= '0;
            s1_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write_en)
            begin
                spb_reg <= cfg_write_data;
            end
            pos_reg      <= pos_next;
            fill_reg     <= fill_next;
            block_reg    <= block_next;
            sym_reg      <= sym_next;
            max_reg      <= max_next;
            xor_reg      <= xor_next;
            s1_valid_reg <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_cmd_reg  <= cmd_next;
            s1_addr_reg <= addr_next;
        end
    end

    assign rd_en    = accept;
    assign rd_addr  = addr_next;
    assign s1_valid = s1_valid_reg;
    assign s1_addr  = s1_addr_reg;
    assign s1_cmd   = s1_cmd_reg;

`ifndef NO_ASSERTIONS
    a_pos_rewinds: assert property (@(posedge clk) disable iff (!rst_n)
        accept && (mode == MODE_DATA) && last_word |=> pos_reg == '0)
        else $error("word position not rewound after last word");
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (fill_reg <= MaxWords) && (pos_reg <= MaxWords))
        else $error("fill mark or word position beyond store depth");
`endif

endmodule

// ===== hdl/xbfe_out_fifo.sv =====
// Small result queue that decouples the output handshake from the pipeline.
module xbfe_out_fifo (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             push,
    input  xbfe_pkg::result_t                push_data,
    input  logic                             out_ready,
    output logic                             out_valid,
    output xbfe_pkg::result_t                head,
    output logic [xbfe_pkg::RES_CNT_W-1:0]   count
);

    import xbfe_pkg::*;

    localparam logic [RES_CNT_W-1:0] LastSlot = RES_CNT_W'(RES_FIFO_DEPTH - 1);

    result_t              entry [RES_FIFO_DEPTH];
    logic [RES_CNT_W-1:0] rd_ptr_reg, wr_ptr_reg, count_reg;
    logic                 pop;

    assign out_valid = count_reg != '0;
    assign pop       = out_valid && out_ready;
    assign head      = entry[rd_ptr_reg];
    assign count     = count_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_ptr_reg <= '0;
            wr_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == LastSlot) ? '0 : wr_ptr_reg + RES_CNT_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == LastSlot) ? '0 : rd_ptr_reg + RES_CNT_W'(1);
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + RES_CNT_W'(1);
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - RES_CNT_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry[wr_ptr_reg] <= push_data;
        end
    end

`ifndef NO_ASSERTIONS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && !pop && (count_reg == RES_CNT_W'(RES_FIFO_DEPTH))))
        else $error("result queue overflow");
    a_push_shows: assert property (@(posedge clk) disable iff (!rst_n)
        push && (count_reg == '0) |=> out_valid && (head == $past(push_data)))
        else $error("pushed result not presented");
`endif

endmodule

// ===== hdl/xor_block_fec_encoder.sv =====
// Top level of the XOR parity block FEC encoder: store merge stage and port wiring.
// The encoder takes one transaction per cycle while in_ready is high, back to back,
// packet data words and repair reads alike. A transaction is accepted at the edge
// where in_valid and in_ready are high; its result (only for the last word of a packet
// or a repair read) passes the merge stage register into a three-entry result queue,
// so in_ready drops only when the queue and the merge stage together hold three
// pending results. The repair store is one MAX_PACKET_WORDS x 64 synchronous RAM: the
// accept stage issues the read, the next stage XORs the masked word into it and writes
// it back, with the previous write forwarded when two transactions in a row touch the
// same entry. No clearing pass runs after reset or between blocks: a fill mark tells
// which words hold data of the current block. The user writes symbols_per_block through
// cfg_write_en/cfg_write_data only while idle; the block itself does not enforce this.
module xor_block_fec_encoder #(
    parameter int MAX_PACKET_WORDS = 256
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_write_en,
    input  logic [xbfe_pkg::SPB_W-1:0]     cfg_write_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic                           mode,
    input  logic [xbfe_pkg::DATA_W-1:0]    data_word,
    input  logic                           last_word,
    input  logic [xbfe_pkg::LEN_W-1:0]     pkt_len,
    input  logic [xbfe_pkg::IDX_W-1:0]     read_index,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [1:0]                     status,
    output logic [xbfe_pkg::BLK_W-1:0]     block_number,
    output logic [xbfe_pkg::SYM_W-1:0]     symbol_number,
    output logic [xbfe_pkg::DATA_W-1:0]    repair_word,
    output logic [xbfe_pkg::LEN_W-1:0]     repair_length,
    output logic [xbfe_pkg::LEN_W-1:0]     length_parity
);

    import xbfe_pkg::*;

    localparam int AW = $clog2(MAX_PACKET_WORDS);

    logic                 accept;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic [DATA_W-1:0]    rd_data;
    logic                 s1_valid;
    logic [AW-1:0]        s1_addr;
    cmd_t                 s1_cmd;

    logic                 wr_valid_reg;
    logic [AW-1:0]        wr_addr_reg;
    logic [DATA_W-1:0]    wr_data_reg;

    logic                 fwd;
    logic [DATA_W-1:0]    base_word, masked_word, merged_word;
    logic                 wr_en;
    logic                 push;
    result_t              push_data, head;
    logic [RES_CNT_W-1:0] fifo_count;

    assign accept = in_valid && in_ready;
    // Hold off input while every queue slot is spoken for.
    assign in_ready = ({1'b0, fifo_count} + {{RES_CNT_W{1'b0}}, push})
                      < (RES_CNT_W + 1)'(RES_FIFO_DEPTH);

    xbfe_ctrl #(
        .MAX_PACKET_WORDS (MAX_PACKET_WORDS)
    ) u_ctrl (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_write_en   (cfg_write_en),
        .cfg_write_data (cfg_write_data),
        .accept         (accept),
        .mode           (mode),
        .data_word      (data_word),
        .last_word      (last_word),
        .pkt_len        (pkt_len),
        .read_index     (read_index),
        .rd_en          (rd_en),
        .rd_addr        (rd_addr),
        .s1_valid       (s1_valid),
        .s1_addr        (s1_addr),
        .s1_cmd         (s1_cmd)
    );

    xbfe_ram #(
        .WIDTH (DATA_W),
        .DEPTH (MAX_PACKET_WORDS)
    ) u_store (
        .clk     (clk),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data),
        .wr_en   (wr_en),
        .wr_addr (s1_addr),
        .wr_data (merged_word)
    );

    // The RAM read in the previous cycle missed a write to the same word.
    assign fwd         = wr_valid_reg && (wr_addr_reg == s1_addr);
    assign base_word   = fwd ? wr_data_reg : rd_data;
    assign masked_word = s1_cmd.hit ? base_word : '0;
    assign merged_word = masked_word ^ s1_cmd.data;
    assign wr_en       = s1_valid && s1_cmd.write_en;
    assign push        = s1_valid && s1_cmd.has_result;

    always_comb
    begin
        push_data.status = s1_cmd.status;
        push_data.block  = s1_cmd.block;
        push_data.symbol = s1_cmd.symbol;
        push_data.word   = (s1_cmd.status == ST_READ) ? masked_word : '0;
        push_data.rlen   = s1_cmd.rlen;
        push_data.lpar   = s1_cmd.lpar;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_valid_reg <= 1'b0;
        end
        else
        begin
            wr_valid_reg <= wr_en;
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            wr_addr_reg <= s1_addr;
            wr_data_reg <= merged_word;
        end
    end

    xbfe_out_fifo u_out_fifo (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (push_data),
        .out_ready (out_ready),
        .out_valid (out_valid),
        .head      (head),
        .count     (fifo_count)
    );

    assign status        = head.status;
    assign block_number  = head.block;
    assign symbol_number = head.symbol;
    assign repair_word   = head.word;
    assign repair_length = head.rlen;
    assign length_parity = head.lpar;

`ifndef NO_ASSERTIONS
    a_stage_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid)
        else $error("accepted transaction did not reach the merge stage");
`endif

endmodule
